@@ src/q2hse_pkg.sv @@
// ----------------------------------------------------------------------------
// Q2 hierarchical shape evaluator package
// Shared widths, codes, payload structs and the rounding helper used by the
// evaluator pipeline.
// ----------------------------------------------------------------------------
package q2hse_pkg;

  localparam int COORD_FRAC_BITS = 14;

  localparam int NBASIS = 9;
  localparam int IDXW   = 4;
  localparam int VW     = 16;
  localparam int JW     = 32;

  localparam logic [IDXW-1:0] BAS_V0 = IDXW'(0);
  localparam logic [IDXW-1:0] BAS_V1 = IDXW'(1);
  localparam logic [IDXW-1:0] BAS_V2 = IDXW'(2);
  localparam logic [IDXW-1:0] BAS_V3 = IDXW'(3);
  localparam logic [IDXW-1:0] BAS_E0 = IDXW'(4);
  localparam logic [IDXW-1:0] BAS_E1 = IDXW'(5);
  localparam logic [IDXW-1:0] BAS_E2 = IDXW'(6);
  localparam logic [IDXW-1:0] BAS_E3 = IDXW'(7);
  localparam logic [IDXW-1:0] BAS_IN = IDXW'(NBASIS - 1);

  // Operand width covers x +/- one and x*x/one - one for any fraction size.
  localparam int LW = ((COORD_FRAC_BITS + 1 > 16) ? COORD_FRAC_BITS + 1 : 16) + 2;
  localparam int AW = ((31 - COORD_FRAC_BITS > COORD_FRAC_BITS + 1) ?
                       31 - COORD_FRAC_BITS : COORD_FRAC_BITS + 1) + 2;
  localparam int OW  = (LW > AW) ? LW : AW;
  localparam int PW  = 2 * OW;
  localparam int TW  = PW - COORD_FRAC_BITS + 1;
  localparam int SW  = 31;
  localparam int MW  = TW + SW;
  localparam int RW  = 80;
  localparam int X2W = 32;
  localparam int JPW = 2 * JW;
  localparam int JSW = JPW + 1;

  localparam int SQRT6_FRAC = 28;
  localparam logic signed [SW-1:0] SQRT6 = SW'(657529896);

  localparam logic [1:0] SH_TWO = 2'd0;
  localparam logic [1:0] SH_FM1 = 2'd1;
  localparam logic [1:0] SH_F   = 2'd2;
  localparam logic [1:0] SH_FP2 = 2'd3;

  localparam logic [1:0] SQ_NONE = 2'd0;
  localparam logic [1:0] SQ_K2   = 2'd1;
  localparam logic [1:0] SQ_K3   = 2'd2;

  localparam int NLANE   = 3;
  localparam int LANE_V  = 0;
  localparam int LANE_GX = 1;
  localparam int LANE_GY = 2;

  typedef logic signed [OW-1:0] opnd_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [TW-1:0] tval_t;
  typedef logic signed [MW-1:0] mval_t;
  typedef logic signed [RW-1:0] wide_t;
  typedef logic [1:0]           code_t;

  localparam opnd_t ONE_OP  = opnd_t'(1 << COORD_FRAC_BITS);
  localparam opnd_t UNIT_OP = opnd_t'(1);

  localparam wide_t VAL_MAX = wide_t'(32767);
  localparam wide_t VAL_MIN = wide_t'(-32768);
  localparam wide_t GRD_MAX = wide_t'(2147483647);
  localparam wide_t GRD_MIN = wide_t'(-2147483647);
  localparam wide_t OUT_MAX = wide_t'(64'sd2147483647);
  localparam wide_t OUT_MIN = wide_t'(-64'sd2147483648);

  typedef struct packed {
    logic signed [JW-1:0] j00;
    logic signed [JW-1:0] j01;
    logic signed [JW-1:0] j10;
    logic signed [JW-1:0] j11;
  } jac_t;

  typedef struct packed {
    logic                 valid;
    logic [IDXW-1:0]      idx;
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    jac_t                 jac;
  } job_t;

  typedef struct packed {
    logic                 valid;
    logic [IDXW-1:0]      idx;
    logic signed [VW-1:0] value;
    logic signed [JW-1:0] ga;
    logic signed [JW-1:0] gb;
    jac_t                 jac;
  } term_t;

  // Divide by 2^s, rounding half away from zero (s is at least one).
  function automatic wide_t rnd_sh(input wide_t v, input int s);
    wide_t h;
    wide_t neg;
    h = '0;
    h[s-1] = 1'b1;
    neg = '0;
    neg[0] = v[RW-1];
    return (v + h - neg) >>> s;
  endfunction

endpackage

@@ src/q2hse_term.sv @@
// ----------------------------------------------------------------------------
// Q2 shape term pipeline
// Seven register stages that turn one (point, basis index) job into the
// saturated basis value and the clamped reference gradient.
// ----------------------------------------------------------------------------
module q2hse_term (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  q2hse_pkg::job_t  job,
  output q2hse_pkg::term_t term
);
  import q2hse_pkg::*;

  logic            st1_valid, st2_valid, st3_valid, st4_valid;
  logic            st5_valid, st6_valid, st7_valid;
  logic [IDXW-1:0] st1_idx, st2_idx, st3_idx, st4_idx, st5_idx, st6_idx, st7_idx;
  jac_t            st1_jac, st2_jac, st3_jac, st4_jac, st5_jac, st6_jac, st7_jac;

  logic signed [X2W-1:0] st1_x2, st1_y2;
  opnd_t st1_x, st1_y, st1_xp, st1_xm, st1_yp, st1_ym;
  opnd_t st2_x, st2_y, st2_xp, st2_xm, st2_yp, st2_ym, st2_ax, st2_ay;

  opnd_t a_next [NLANE];
  opnd_t b_next [NLANE];
  code_t sh_next [NLANE];
  code_t sq_next [NLANE];
  opnd_t st3_a [NLANE];
  opnd_t st3_b [NLANE];
  code_t st3_sh [NLANE];
  code_t st3_sq [NLANE];

  prod_t st4_p [NLANE];
  code_t st4_sh [NLANE];
  code_t st4_sq [NLANE];

  tval_t t_next [NLANE];
  tval_t st5_t [NLANE];
  code_t st5_sq [NLANE];

  mval_t st6_m [NLANE];
  tval_t st6_t [NLANE];
  code_t st6_sq [NLANE];

  wide_t                r_next [NLANE];
  logic signed [VW-1:0] val_next;
  logic signed [JW-1:0] ga_next, gb_next;
  logic signed [VW-1:0] st7_val;
  logic signed [JW-1:0] st7_ga, st7_gb;

  opnd_t nx, ny, nxp, nxm, nyp, nym, nax, nay;

  always_ff @(posedge clk) begin
    if (rst) begin
      st1_valid <= 1'b0;
      st2_valid <= 1'b0;
      st3_valid <= 1'b0;
      st4_valid <= 1'b0;
      st5_valid <= 1'b0;
      st6_valid <= 1'b0;
      st7_valid <= 1'b0;
    end else if (en) begin
      st1_valid <= job.valid;
      st2_valid <= st1_valid;
      st3_valid <= st2_valid;
      st4_valid <= st3_valid;
      st5_valid <= st4_valid;
      st6_valid <= st5_valid;
      st7_valid <= st6_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st1_idx <= job.idx;
      st1_jac <= job.jac;
      st1_x   <= opnd_t'(job.x);
      st1_y   <= opnd_t'(job.y);
      st1_x2  <= X2W'(job.x) * X2W'(job.x);
      st1_y2  <= X2W'(job.y) * X2W'(job.y);
      st1_xp  <= opnd_t'(job.x) + ONE_OP;
      st1_xm  <= opnd_t'(job.x) - ONE_OP;
      st1_yp  <= opnd_t'(job.y) + ONE_OP;
      st1_ym  <= opnd_t'(job.y) - ONE_OP;

      st2_idx <= st1_idx;
      st2_jac <= st1_jac;
      st2_x   <= st1_x;
      st2_y   <= st1_y;
      st2_xp  <= st1_xp;
      st2_xm  <= st1_xm;
      st2_yp  <= st1_yp;
      st2_ym  <= st1_ym;
      st2_ax  <= opnd_t'(rnd_sh(wide_t'(st1_x2), COORD_FRAC_BITS)) - ONE_OP;
      st2_ay  <= opnd_t'(rnd_sh(wide_t'(st1_y2), COORD_FRAC_BITS)) - ONE_OP;

      st3_idx <= st2_idx;
      st3_jac <= st2_jac;
      st4_idx <= st3_idx;
      st4_jac <= st3_jac;
      st5_idx <= st4_idx;
      st5_jac <= st4_jac;
      st6_idx <= st5_idx;
      st6_jac <= st5_jac;
      st7_idx <= st6_idx;
      st7_jac <= st6_jac;

      for (int l = 0; l < NLANE; l++) begin
        st3_a[l]  <= a_next[l];
        st3_b[l]  <= b_next[l];
        st3_sh[l] <= sh_next[l];
        st3_sq[l] <= sq_next[l];
        st4_p[l]  <= PW'(st3_a[l]) * PW'(st3_b[l]);
        st4_sh[l] <= st3_sh[l];
        st4_sq[l] <= st3_sq[l];
        st5_t[l]  <= t_next[l];
        st5_sq[l] <= st4_sq[l];
        st6_m[l]  <= MW'(st5_t[l]) * MW'(SQRT6);
        st6_t[l]  <= st5_t[l];
        st6_sq[l] <= st5_sq[l];
      end

      st7_val <= val_next;
      st7_ga  <= ga_next;
      st7_gb  <= gb_next;
    end
  end

  assign nx  = -st2_x;
  assign ny  = -st2_y;
  assign nxp = -st2_xp;
  assign nxm = -st2_xm;
  assign nyp = -st2_yp;
  assign nym = -st2_ym;
  assign nax = -st2_ax;
  assign nay = -st2_ay;

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      a_next[l]  = '0;
      b_next[l]  = ONE_OP;
      sh_next[l] = SH_F;
      sq_next[l] = SQ_NONE;
    end
    case (st2_idx)
      BAS_V0, BAS_V1, BAS_V2, BAS_V3: begin
        sh_next[LANE_V]  = SH_FP2;
        sh_next[LANE_GX] = SH_TWO;
        sh_next[LANE_GY] = SH_TWO;
        b_next[LANE_GX]  = UNIT_OP;
        b_next[LANE_GY]  = UNIT_OP;
        case (st2_idx)
          BAS_V0: begin
            a_next[LANE_V] = st2_xm;  b_next[LANE_V] = st2_ym;
            a_next[LANE_GX] = st2_ym; a_next[LANE_GY] = st2_xm;
          end
          BAS_V1: begin
            a_next[LANE_V] = nxp;     b_next[LANE_V] = st2_ym;
            a_next[LANE_GX] = nym;    a_next[LANE_GY] = nxp;
          end
          BAS_V2: begin
            a_next[LANE_V] = st2_xp;  b_next[LANE_V] = st2_yp;
            a_next[LANE_GX] = st2_yp; a_next[LANE_GY] = st2_xp;
          end
          default: begin
            a_next[LANE_V] = nxm;     b_next[LANE_V] = st2_yp;
            a_next[LANE_GX] = nyp;    a_next[LANE_GY] = nxm;
          end
        endcase
      end
      BAS_E0: begin
        a_next[LANE_V]  = nax;  b_next[LANE_V]  = st2_ym; sq_next[LANE_V]  = SQ_K3;
        a_next[LANE_GX] = nx;   b_next[LANE_GX] = st2_ym; sq_next[LANE_GX] = SQ_K2;
        a_next[LANE_GY] = nax;                            sq_next[LANE_GY] = SQ_K3;
      end
      BAS_E1: begin
        a_next[LANE_V]  = st2_ay; b_next[LANE_V]  = st2_xp; sq_next[LANE_V]  = SQ_K3;
        a_next[LANE_GX] = st2_ay;                           sq_next[LANE_GX] = SQ_K3;
        a_next[LANE_GY] = st2_y;  b_next[LANE_GY] = st2_xp; sq_next[LANE_GY] = SQ_K2;
      end
      BAS_E2: begin
        a_next[LANE_V]  = st2_ax; b_next[LANE_V]  = st2_yp; sq_next[LANE_V]  = SQ_K3;
        a_next[LANE_GX] = st2_x;  b_next[LANE_GX] = st2_yp; sq_next[LANE_GX] = SQ_K2;
        a_next[LANE_GY] = st2_ax;                           sq_next[LANE_GY] = SQ_K3;
      end
      BAS_E3: begin
        a_next[LANE_V]  = nay;  b_next[LANE_V]  = st2_xm; sq_next[LANE_V]  = SQ_K3;
        a_next[LANE_GX] = nay;                            sq_next[LANE_GX] = SQ_K3;
        a_next[LANE_GY] = ny;   b_next[LANE_GY] = st2_xm; sq_next[LANE_GY] = SQ_K2;
      end
      BAS_IN: begin
        a_next[LANE_V]  = st2_ax; b_next[LANE_V]  = st2_ay;
        a_next[LANE_GX] = st2_x;  b_next[LANE_GX] = st2_ay; sh_next[LANE_GX] = SH_FM1;
        a_next[LANE_GY] = st2_y;  b_next[LANE_GY] = st2_ax; sh_next[LANE_GY] = SH_FM1;
      end
      default: begin
        a_next[LANE_V] = '0;
      end
    endcase
  end

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      case (st4_sh[l])
        SH_TWO:  t_next[l] = tval_t'(rnd_sh(wide_t'(st4_p[l]), 2));
        SH_FM1:  t_next[l] = tval_t'(rnd_sh(wide_t'(st4_p[l]), COORD_FRAC_BITS - 1));
        SH_F:    t_next[l] = tval_t'(rnd_sh(wide_t'(st4_p[l]), COORD_FRAC_BITS));
        default: t_next[l] = tval_t'(rnd_sh(wide_t'(st4_p[l]), COORD_FRAC_BITS + 2));
      endcase
    end
  end

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      case (st6_sq[l])
        SQ_K2:   r_next[l] = rnd_sh(wide_t'(st6_m[l]), SQRT6_FRAC + 2);
        SQ_K3:   r_next[l] = rnd_sh(wide_t'(st6_m[l]), SQRT6_FRAC + 3);
        default: r_next[l] = wide_t'(st6_t[l]);
      endcase
    end

    if (r_next[LANE_V] > VAL_MAX) begin
      val_next = VW'(VAL_MAX);
    end else if (r_next[LANE_V] < VAL_MIN) begin
      val_next = VW'(VAL_MIN);
    end else begin
      val_next = VW'(r_next[LANE_V]);
    end

    if (r_next[LANE_GX] > GRD_MAX) begin
      ga_next = JW'(GRD_MAX);
    end else if (r_next[LANE_GX] < GRD_MIN) begin
      ga_next = JW'(GRD_MIN);
    end else begin
      ga_next = JW'(r_next[LANE_GX]);
    end

    if (r_next[LANE_GY] > GRD_MAX) begin
      gb_next = JW'(GRD_MAX);
    end else if (r_next[LANE_GY] < GRD_MIN) begin
      gb_next = JW'(GRD_MIN);
    end else begin
      gb_next = JW'(r_next[LANE_GY]);
    end
  end

  assign term = '{valid: st7_valid, idx: st7_idx, value: st7_val,
                  ga: st7_ga, gb: st7_gb, jac: st7_jac};

endmodule

@@ src/q2hse_jac.sv @@
// ----------------------------------------------------------------------------
// Q2 shape Jacobian stage
// Three register stages that multiply the reference gradient by the inverse
// Jacobian, round, saturate and hold the result item for the output channel.
// ----------------------------------------------------------------------------
module q2hse_jac (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  q2hse_pkg::term_t                   term,
  output logic                               out_valid,
  output logic [q2hse_pkg::IDXW-1:0]         basis_index,
  output logic signed [q2hse_pkg::VW-1:0]    basis_value,
  output logic signed [q2hse_pkg::JW-1:0]    grad_x,
  output logic signed [q2hse_pkg::JW-1:0]    grad_y,
  output logic                               last
);
  import q2hse_pkg::*;

  logic                  jp_valid, js_valid;
  logic [IDXW-1:0]       jp_idx, js_idx;
  logic signed [VW-1:0]  jp_val, js_val;
  logic signed [JPW-1:0] jp_00, jp_01, jp_10, jp_11;
  logic signed [JSW-1:0] js_x, js_y;
  wide_t                 rx, ry;
  logic signed [JW-1:0]  gx_next, gy_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      jp_valid  <= 1'b0;
      js_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      jp_valid  <= term.valid;
      js_valid  <= jp_valid;
      out_valid <= js_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      jp_idx <= term.idx;
      jp_val <= term.value;
      jp_00  <= JPW'(term.jac.j00) * JPW'(term.ga);
      jp_01  <= JPW'(term.jac.j01) * JPW'(term.gb);
      jp_10  <= JPW'(term.jac.j10) * JPW'(term.ga);
      jp_11  <= JPW'(term.jac.j11) * JPW'(term.gb);

      js_idx <= jp_idx;
      js_val <= jp_val;
      js_x   <= JSW'(jp_00) + JSW'(jp_01);
      js_y   <= JSW'(jp_10) + JSW'(jp_11);

      basis_index <= js_idx;
      basis_value <= js_val;
      grad_x      <= gx_next;
      grad_y      <= gy_next;
      last        <= (js_idx == BAS_IN);
    end
  end

  always_comb begin
    rx = rnd_sh(wide_t'(js_x), COORD_FRAC_BITS);
    ry = rnd_sh(wide_t'(js_y), COORD_FRAC_BITS);

    if (rx > OUT_MAX) begin
      gx_next = JW'(OUT_MAX);
    end else if (rx < OUT_MIN) begin
      gx_next = JW'(OUT_MIN);
    end else begin
      gx_next = JW'(rx);
    end

    if (ry > OUT_MAX) begin
      gy_next = JW'(OUT_MAX);
    end else if (ry < OUT_MIN) begin
      gy_next = JW'(OUT_MIN);
    end else begin
      gy_next = JW'(ry);
    end
  end

endmodule

@@ src/q2_hierarchical_shape_eval_top.sv @@
// ----------------------------------------------------------------------------
// Q2 hierarchical shape function evaluator
// Takes one reference point with its inverse Jacobian and returns the value
// and physical gradient of all nine Q2 hierarchical basis functions.
//
// Input channel: in_valid/in_stall with x_coord, y_coord and jinv_00..11.
// Output channel: out_valid/out_stall with basis_index, basis_value, grad_x,
// grad_y and last. Each point gives nine result items, basis 0 to 8 in order,
// with last set on the ninth.
// A point is held in an issue register that sends one basis job per cycle,
// unless the pipeline is held, into a ten-stage pipeline (seven shape
// stages, three Jacobian stages). Points share the single result lane: a
// new point is accepted in the cycle its predecessor's last job issues.
// When out_stall is high with a result item waiting, the whole pipeline and
// a busy issue register hold; nothing is dropped or repeated.
// Reset clears the issue state and all stage valid bits; the first point may
// be presented in the cycle after reset is released.
// ----------------------------------------------------------------------------
module q2_hierarchical_shape_eval_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [15:0]                 x_coord,
  input  logic signed [15:0]                 y_coord,
  input  logic signed [31:0]                 jinv_00,
  input  logic signed [31:0]                 jinv_01,
  input  logic signed [31:0]                 jinv_10,
  input  logic signed [31:0]                 jinv_11,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [q2hse_pkg::IDXW-1:0]         basis_index,
  output logic signed [q2hse_pkg::VW-1:0]    basis_value,
  output logic signed [q2hse_pkg::JW-1:0]    grad_x,
  output logic signed [q2hse_pkg::JW-1:0]    grad_y,
  output logic                               last
);
  import q2hse_pkg::*;

  logic                 en;
  logic                 take;
  logic                 busy;
  logic [IDXW-1:0]      cnt;
  logic signed [VW-1:0] pt_x, pt_y;
  jac_t                 pt_jac;
  job_t                 job;
  term_t                term_q;

  assign en       = !out_valid || !out_stall;
  assign in_stall = busy && !(en && cnt == BAS_IN);
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= BAS_V0;
    end else if (take) begin
      busy <= 1'b1;
      cnt  <= BAS_V0;
    end else if (busy && en) begin
      if (cnt == BAS_IN) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt + IDXW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pt_x   <= x_coord;
      pt_y   <= y_coord;
      pt_jac <= '{j00: jinv_00, j01: jinv_01, j10: jinv_10, j11: jinv_11};
    end
  end

  assign job = '{valid: busy, idx: cnt, x: pt_x, y: pt_y, jac: pt_jac};

  q2hse_term u_term (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .job  (job),
    .term (term_q)
  );

  q2hse_jac u_jac (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .term        (term_q),
    .out_valid   (out_valid),
    .basis_index (basis_index),
    .basis_value (basis_value),
    .grad_x      (grad_x),
    .grad_y      (grad_y),
    .last        (last)
  );

endmodule
